@@ src/irt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// irt_pkg: innovation record table shared definitions
// Sizes, command and status codes, record type and counter restart rule.
// ----------------------------------------------------------------------------
package irt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int ID_BITS       = 16;
	localparam int FIELD_W       = 16;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

	localparam logic [31:0] ID_MAX = (32'd1 << ID_BITS) - 32'd1;

	localparam logic [2:0] CMD_FIND_FIRST = 3'd0;
	localparam logic [2:0] CMD_FIND_LAST  = 3'd1;
	localparam logic [2:0] CMD_LIST_ALL   = 3'd2;
	localparam logic [2:0] CMD_ADD_LINK   = 3'd3;
	localparam logic [2:0] CMD_ADD_NEURON = 3'd4;
	localparam logic [2:0] CMD_FLUSH      = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_INVALID   = 3'd2;
	localparam logic [2:0] ST_EXHAUSTED = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	localparam logic REG_START_INNOV  = 1'b0;
	localparam logic REG_START_NEURON = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [FIELD_W-1:0] src;
		logic [FIELD_W-1:0] tgt;
		logic [FIELD_W-1:0] innov;
		logic [FIELD_W-1:0] neuron;
	} rec_t;

	typedef struct packed {
		logic start;
		logic adv;
		logic clr;
	} cell_ctl_t;

	function automatic logic [FIELD_W-1:0] restart_value(input logic [FIELD_W-1:0] last_used);
		logic [31:0] wide;
		wide = 32'(last_used);
		if (wide >= ID_MAX) begin
			return ID_MAX[FIELD_W-1:0];
		end
		return last_used + FIELD_W'(1);
	endfunction

endpackage
`default_nettype wire

@@ src/irt_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// irt_if: command and result channels
// Valid/ready channels carrying one command word and one result word.
// ----------------------------------------------------------------------------
interface irt_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic        record_kind;
	logic [15:0] source_id;
	logic [15:0] target_id;
	logic        is_hidden;

	modport source(output valid, cmd, record_kind, source_id, target_id, is_hidden,
		input ready);
	modport sink(input valid, cmd, record_kind, source_id, target_id, is_hidden,
		output ready);
endinterface

interface irt_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] innovation_num;
	logic [15:0] neuron_num;
	logic [5:0]  entry_index;
	logic        last;

	modport source(output valid, status, innovation_num, neuron_num, entry_index, last,
		input ready);
	modport sink(input valid, status, innovation_num, neuron_num, entry_index, last,
		output ready);
endinterface
`default_nettype wire

@@ src/irt_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// irt_cell: one table entry
// Holds one record, compares it with the search key while the scan token
// sits here, and hands the token on to the next cell.
// ----------------------------------------------------------------------------
module irt_cell (
	input  wire                          clk,
	input  wire                          arst_n,
	input  irt_pkg::cell_ctl_t           ctl,
	input  wire                          tok_in,
	output logic                         tok_out,
	input  wire                          wr_en,
	input  irt_pkg::rec_t                wdata,
	input  wire                          key_kind,
	input  wire [irt_pkg::FIELD_W-1:0]   key_src,
	input  wire [irt_pkg::FIELD_W-1:0]   key_tgt,
	output logic                         hit,
	output irt_pkg::rec_t                rdata
);
	import irt_pkg::*;

	rec_t rec_q;
	logic tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (ctl.clr) begin
			tok_q <= 1'b0;
		end else if (ctl.start || ctl.adv) begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rec_q <= wdata;
		end
	end

	assign tok_out = tok_q;
	assign hit     = tok_q && (rec_q.kind == key_kind) && (rec_q.src == key_src)
		&& (rec_q.tgt == key_tgt);
	assign rdata   = tok_q ? rec_q : '0;

endmodule
`default_nettype wire

@@ src/innovation_record_table_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// innovation_record_table_top: append-only innovation record table
// Record table with lookup, listing, append and flush commands.
// ----------------------------------------------------------------------------
// Appends, flushes and rejected commands load their result in the execute
// state. A lookup or listing passes a scan token along the row of entry
// cells, one entry per cycle unless a listing waits for the result channel
// to take an earlier match; a listing that ends with matches sends its final
// word from the tail state, and all of it takes longer where the result
// channel stalls. One command is worked at a time; a finished result waits in
// the output register while the next command is taken. The start registers
// take effect at the next flush.
module innovation_record_table_top (
	input  wire         clk,
	input  wire         arst_n,
	irt_in_if.sink      in_w,
	irt_out_if.source   out_w,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import irt_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_TAIL = 2'd3;

	logic [1:0]         state_q, state_d;
	logic [2:0]         cmd_q;
	logic               kind_q, hidden_q;
	logic [FIELD_W-1:0] src_q, tgt_q;
	logic [CNT_W-1:0]   fill_q;
	logic [IDX_W-1:0]   idx_q;
	logic [FIELD_W-1:0] next_innov_q, next_neuron_q;
	logic [FIELD_W-1:0] start_innov_q, start_neuron_q;
	rec_t               held_q;
	logic [IDX_W-1:0]   held_idx_q;
	logic               have_q;

	logic               ov_q;
	logic [2:0]         o_status_q;
	logic [FIELD_W-1:0] o_innov_q, o_neuron_q;
	logic [IDX_W-1:0]   o_idx_q;
	logic               o_last_q;

	logic               o_load, o_last;
	logic [2:0]         o_status;
	logic [FIELD_W-1:0] o_innov, o_neuron;
	logic [IDX_W-1:0]   o_idx;

	cell_ctl_t          ctl;
	logic               wr, do_flush, held_load, have_clr;
	logic [TABLE_ENTRIES-1:0] tok, hit_v, wr_en;
	rec_t               rdata_v [TABLE_ENTRIES];
	rec_t               cur, wdata;
	logic               hit, free, at_end, bad_ends, split, exhaust;

	// configuration
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_innov_q  <= '0;
			start_neuron_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_START_INNOV) begin
				start_innov_q <= pwdata[FIELD_W-1:0];
			end else begin
				start_neuron_q <= pwdata[FIELD_W-1:0];
			end
		end
	end
	assign prdata = (paddr[2] == REG_START_INNOV) ? 32'(start_innov_q) : 32'(start_neuron_q);

	// cell row
	assign wdata = '{kind: split, src: src_q, tgt: tgt_q, innov: next_innov_q,
		neuron: split ? next_neuron_q : '0};

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		assign wr_en[i] = wr && (fill_q[IDX_W-1:0] == IDX_W'(i));
		irt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.tok_in  ((i == 0) ? ctl.start : tok[(i == 0) ? 0 : i-1]),
			.tok_out (tok[i]),
			.wr_en   (wr_en[i]),
			.wdata   (wdata),
			.key_kind(kind_q),
			.key_src (src_q),
			.key_tgt (tgt_q),
			.hit     (hit_v[i]),
			.rdata   (rdata_v[i])
		);
	end

	always_comb begin
		cur = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			cur = cur | rdata_v[i];
		end
	end

	assign hit      = |hit_v;
	assign free     = !ov_q || out_w.ready;
	assign at_end   = ((CNT_W'(idx_q) + CNT_W'(1)) == fill_q);
	assign bad_ends = (src_q == '0) || (tgt_q == '0);
	assign split    = (cmd_q == CMD_ADD_NEURON);
	assign exhaust  = (32'(next_innov_q) >= ID_MAX) || (split && (32'(next_neuron_q) >= ID_MAX));

	always_comb begin
		state_d   = state_q;
		o_load    = 1'b0;
		o_status  = ST_OK;
		o_innov   = '0;
		o_neuron  = '0;
		o_idx     = '0;
		o_last    = 1'b1;
		ctl       = '0;
		wr        = 1'b0;
		do_flush  = 1'b0;
		held_load = 1'b0;
		have_clr  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_w.valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (cmd_q)
					CMD_FIND_FIRST, CMD_FIND_LAST, CMD_LIST_ALL: begin
						if (bad_ends || fill_q == '0) begin
							if (free) begin
								o_load   = 1'b1;
								o_status = bad_ends ? ST_INVALID : ST_NOT_FOUND;
								state_d  = S_IDLE;
							end
						end else begin
							ctl.start = 1'b1;
							have_clr  = 1'b1;
							state_d   = S_SCAN;
						end
					end
					CMD_ADD_LINK, CMD_ADD_NEURON: begin
						if (free) begin
							o_load  = 1'b1;
							state_d = S_IDLE;
							if (bad_ends || (split && !hidden_q)) begin
								o_status = ST_INVALID;
							end else if (exhaust) begin
								o_status = ST_EXHAUSTED;
							end else if (fill_q == CNT_W'(TABLE_ENTRIES)) begin
								o_status = ST_FULL;
							end else begin
								wr       = 1'b1;
								o_innov  = wdata.innov;
								o_neuron = wdata.neuron;
								o_idx    = fill_q[IDX_W-1:0];
							end
						end
					end
					CMD_FLUSH: begin
						if (free) begin
							o_load   = 1'b1;
							do_flush = 1'b1;
							state_d  = S_IDLE;
						end
					end
					default: begin
						if (free) begin
							o_load   = 1'b1;
							o_status = ST_INVALID;
							state_d  = S_IDLE;
						end
					end
				endcase
			end
			S_SCAN: begin
				case (cmd_q)
					CMD_FIND_FIRST: begin
						if (hit || at_end) begin
							if (free) begin
								o_load   = 1'b1;
								o_status = hit ? ST_OK : ST_NOT_FOUND;
								o_innov  = hit ? cur.innov : '0;
								o_neuron = hit ? cur.neuron : '0;
								o_idx    = hit ? idx_q : '0;
								ctl.clr  = 1'b1;
								state_d  = S_IDLE;
							end
						end else begin
							ctl.adv = 1'b1;
						end
					end
					CMD_FIND_LAST: begin
						if (at_end) begin
							if (free) begin
								o_load   = 1'b1;
								o_status = (hit || have_q) ? ST_OK : ST_NOT_FOUND;
								o_innov  = hit ? cur.innov : (have_q ? held_q.innov : '0);
								o_neuron = hit ? cur.neuron : (have_q ? held_q.neuron : '0);
								o_idx    = hit ? idx_q : (have_q ? held_idx_q : '0);
								ctl.clr  = 1'b1;
								state_d  = S_IDLE;
							end
						end else begin
							held_load = hit;
							ctl.adv   = 1'b1;
						end
					end
					default: begin
						if (!(hit && have_q && !free)) begin
							if (hit && have_q) begin
								o_load   = 1'b1;
								o_innov  = held_q.innov;
								o_neuron = held_q.neuron;
								o_idx    = held_idx_q;
								o_last   = 1'b0;
							end
							held_load = hit;
							if (!at_end) begin
								ctl.adv = 1'b1;
							end else if (hit || have_q) begin
								ctl.clr = 1'b1;
								state_d = S_TAIL;
							end else if (free) begin
								o_load   = 1'b1;
								o_status = ST_NOT_FOUND;
								ctl.clr  = 1'b1;
								state_d  = S_IDLE;
							end
						end
					end
				endcase
			end
			default: begin
				if (free) begin
					o_load   = 1'b1;
					o_innov  = held_q.innov;
					o_neuron = held_q.neuron;
					o_idx    = held_idx_q;
					state_d  = S_IDLE;
				end
			end
		endcase
	end

	assign in_w.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			fill_q        <= '0;
			idx_q         <= '0;
			have_q        <= 1'b0;
			ov_q          <= 1'b0;
			next_innov_q  <= restart_value('0);
			next_neuron_q <= restart_value('0);
		end else begin
			state_q <= state_d;
			if (ctl.start) begin
				idx_q <= '0;
			end else if (ctl.adv) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (have_clr) begin
				have_q <= 1'b0;
			end else if (held_load) begin
				have_q <= 1'b1;
			end
			if (wr) begin
				fill_q       <= fill_q + CNT_W'(1);
				next_innov_q <= next_innov_q + FIELD_W'(1);
				if (split) begin
					next_neuron_q <= next_neuron_q + FIELD_W'(1);
				end
			end else if (do_flush) begin
				fill_q        <= '0;
				next_innov_q  <= restart_value(start_innov_q);
				next_neuron_q <= restart_value(start_neuron_q);
			end
			if (o_load) begin
				ov_q <= 1'b1;
			end else if (out_w.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_w.valid && in_w.ready) begin
			cmd_q    <= in_w.cmd;
			kind_q   <= in_w.record_kind;
			src_q    <= in_w.source_id;
			tgt_q    <= in_w.target_id;
			hidden_q <= in_w.is_hidden;
		end
		if (held_load) begin
			held_q     <= cur;
			held_idx_q <= idx_q;
		end
		if (o_load) begin
			o_status_q <= o_status;
			o_innov_q  <= o_innov;
			o_neuron_q <= o_neuron;
			o_idx_q    <= o_idx;
			o_last_q   <= o_last;
		end
	end

	assign out_w.valid          = ov_q;
	assign out_w.status         = o_status_q;
	assign out_w.innovation_num = o_innov_q;
	assign out_w.neuron_num     = o_neuron_q;
	assign out_w.entry_index    = 6'(o_idx_q);
	assign out_w.last           = o_last_q;

	a_tok_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(tok))
		else $error("scan token held by more than one cell");
	a_idle_no_tok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (tok == '0))
		else $error("scan token left in the row after a command");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(TABLE_ENTRIES))
		else $error("fill count beyond table size");
	a_scan_tok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> $onehot(tok))
		else $error("scan running without a token");

endmodule
`default_nettype wire

@@ sim/tb_innovation_record_table_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_innovation_record_table_top: record table command and result checks
// Drives lookup, listing, append and flush commands over valid/ready channels,
// predicts every result word from a local copy of the table and counters, and
// compares result words in order. Start registers change between phases.
// ----------------------------------------------------------------------------
import irt_pkg::*;

typedef struct packed {
	logic [2:0]  status;
	logic [15:0] innov;
	logic [15:0] neuron;
	logic [5:0]  index;
	logic        last;
} irt_result_t;

class irt_scoreboard;
	logic        tbl_kind[TABLE_ENTRIES];
	logic [15:0] tbl_src[TABLE_ENTRIES];
	logic [15:0] tbl_tgt[TABLE_ENTRIES];
	logic [15:0] tbl_innov[TABLE_ENTRIES];
	logic [15:0] tbl_neuron[TABLE_ENTRIES];
	int          fill;
	logic [15:0] next_innov;
	logic [15:0] next_neuron;
	logic [15:0] start_innov;
	logic [15:0] start_neuron;
	irt_result_t pending[$];
	int          errors;
	int          checked;

	function new();
		fill = 0;
		next_innov = 16'd1;
		next_neuron = 16'd1;
		start_innov = '0;
		start_neuron = '0;
		errors = 0;
		checked = 0;
	endfunction

	function logic [15:0] reload(logic [15:0] last_used);
		if (last_used == 16'hFFFF || last_used == 16'hFFFE) return 16'hFFFF;
		return last_used + 16'd1;
	endfunction

	function void push(logic [2:0] st, logic [15:0] inn, logic [15:0] neu,
			logic [5:0] idx, logic lst);
		irt_result_t r;
		r.status = st;
		r.innov = inn;
		r.neuron = neu;
		r.index = idx;
		r.last = lst;
		pending.insert(pending.size(), r);
	endfunction

	function bit hit(int i, logic k, logic [15:0] s, logic [15:0] t);
		return tbl_kind[i] == k && tbl_src[i] == s && tbl_tgt[i] == t;
	endfunction

	function void note_command(logic [2:0] cmd, logic k, logic [15:0] s,
			logic [15:0] t, logic hid);
		bit bad;
		int found;
		int hits[$];
		bad = (s == 0) || (t == 0);
		found = -1;
		case (cmd)
			CMD_FIND_FIRST, CMD_FIND_LAST: begin
				if (bad) begin
					push(ST_INVALID, 0, 0, 0, 1);
					return;
				end
				for (int i = 0; i < fill; i++)
					if (hit(i, k, s, t) && (found < 0 || cmd == CMD_FIND_LAST)) found = i;
				if (found < 0) push(ST_NOT_FOUND, 0, 0, 0, 1);
				else push(ST_OK, tbl_innov[found], tbl_neuron[found], found[5:0], 1);
			end
			CMD_LIST_ALL: begin
				if (bad) begin
					push(ST_INVALID, 0, 0, 0, 1);
					return;
				end
				for (int i = 0; i < fill; i++)
					if (hit(i, k, s, t)) hits.insert(hits.size(), i);
				if (hits.size() == 0) push(ST_NOT_FOUND, 0, 0, 0, 1);
				foreach (hits[j])
					push(ST_OK, tbl_innov[hits[j]], tbl_neuron[hits[j]], hits[j][5:0],
						j == hits.size() - 1);
			end
			CMD_ADD_LINK, CMD_ADD_NEURON: begin
				if (bad || (cmd == CMD_ADD_NEURON && !hid)) push(ST_INVALID, 0, 0, 0, 1);
				else if (next_innov == 16'hFFFF ||
						(cmd == CMD_ADD_NEURON && next_neuron == 16'hFFFF))
					push(ST_EXHAUSTED, 0, 0, 0, 1);
				else if (fill >= TABLE_ENTRIES) push(ST_FULL, 0, 0, 0, 1);
				else begin
					tbl_kind[fill] = (cmd == CMD_ADD_NEURON);
					tbl_src[fill] = s;
					tbl_tgt[fill] = t;
					tbl_innov[fill] = next_innov;
					tbl_neuron[fill] = (cmd == CMD_ADD_NEURON) ? next_neuron : 16'd0;
					push(ST_OK, tbl_innov[fill], tbl_neuron[fill], fill[5:0], 1);
					fill++;
					next_innov++;
					if (cmd == CMD_ADD_NEURON) next_neuron++;
				end
			end
			CMD_FLUSH: begin
				fill = 0;
				next_innov = reload(start_innov);
				next_neuron = reload(start_neuron);
				push(ST_OK, 0, 0, 0, 1);
			end
			default: push(ST_INVALID, 0, 0, 0, 1);
		endcase
	endfunction

	function void check_result(irt_result_t got);
		irt_result_t exp_r;
		checked++;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result word %h", $time, got);
			errors++;
			return;
		end
		exp_r = pending.pop_front();
		if (got !== exp_r) begin
			$display("%0t: expected st=%0d inn=%0d neu=%0d idx=%0d last=%0d, got st=%0d inn=%0d neu=%0d idx=%0d last=%0d",
				$time, exp_r.status, exp_r.innov, exp_r.neuron, exp_r.index, exp_r.last,
				got.status, got.innov, got.neuron, got.index, got.last);
			errors++;
		end
	endfunction
endclass

module tb_innovation_record_table_top;
	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          send_idle_pct;
	int          stall_pct;
	int          hold_off;
	irt_scoreboard board;

	irt_in_if  in_w();
	irt_out_if out_w();

	innovation_record_table_top u_dut (
		.clk(clk), .arst_n(arst_n), .in_w(in_w), .out_w(out_w),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_w.ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_w.ready <= 1'b0;
		end else begin
			out_w.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		irt_result_t got;
		if (arst_n && out_w.valid && out_w.ready) begin
			got.status = out_w.status;
			got.innov = out_w.innovation_num;
			got.neuron = out_w.neuron_num;
			got.index = out_w.entry_index;
			got.last = out_w.last;
			board.check_result(got);
		end
	end

	task automatic write_reg(logic [2:0] addr, logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == 3'd0) board.start_innov = value;
		else board.start_neuron = value;
		@(posedge clk);
	endtask

	task automatic send_word(logic [2:0] cmd, logic k, logic [15:0] s, logic [15:0] t,
			logic hid);
		while ($urandom_range(99) < send_idle_pct) begin
			in_w.valid <= 1'b0;
			@(posedge clk);
		end
		in_w.valid <= 1'b1;
		in_w.cmd <= cmd;
		in_w.record_kind <= k;
		in_w.source_id <= s;
		in_w.target_id <= t;
		in_w.is_hidden <= hid;
		do @(posedge clk); while (!in_w.ready);
		board.note_command(cmd, k, s, t, hid);
	endtask

	task automatic drain();
		in_w.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic random_word();
		logic [2:0]  cmd;
		logic [15:0] s;
		logic [15:0] t;
		int          r;
		r = $urandom_range(99);
		if (r < 30) cmd = CMD_ADD_LINK;
		else if (r < 50) cmd = CMD_ADD_NEURON;
		else if (r < 62) cmd = CMD_FIND_FIRST;
		else if (r < 74) cmd = CMD_FIND_LAST;
		else if (r < 88) cmd = CMD_LIST_ALL;
		else if (r < 92) cmd = CMD_FLUSH;
		else cmd = 3'($urandom_range(7));
		r = $urandom_range(99);
		if (r < 70) begin
			s = 16'($urandom_range(1, 4));
			t = 16'($urandom_range(1, 4));
		end else if (r < 94) begin
			s = 16'($urandom_range(1, 65535));
			t = 16'($urandom_range(1, 65535));
		end else begin
			s = 16'($urandom_range(1)) ? 16'd0 : 16'($urandom);
			t = 16'($urandom_range(1)) ? 16'd0 : 16'($urandom);
		end
		send_word(cmd, 1'($urandom), s, t, $urandom_range(9) != 0);
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_off = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		in_w.valid = 1'b0;
		in_w.cmd = '0;
		in_w.record_kind = 1'b0;
		in_w.source_id = '0;
		in_w.target_id = '0;
		in_w.is_hidden = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(CMD_FIND_FIRST, 0, 16'd1, 16'd2, 0);
		send_word(CMD_ADD_LINK, 0, 16'd1, 16'd2, 0);
		send_word(CMD_ADD_NEURON, 0, 16'd1, 16'd2, 1);
		send_word(CMD_ADD_LINK, 0, 16'hFFFF, 16'hFFFF, 0);
		send_word(CMD_ADD_LINK, 0, 16'd1, 16'd2, 0);
		send_word(CMD_ADD_NEURON, 0, 16'd1, 16'd2, 1);
		send_word(CMD_ADD_NEURON, 0, 16'd3, 16'd4, 0);
		send_word(CMD_FIND_FIRST, 0, 16'd1, 16'd2, 0);
		send_word(CMD_FIND_LAST, 0, 16'd1, 16'd2, 0);
		send_word(CMD_FIND_LAST, 1, 16'd1, 16'd2, 0);
		send_word(CMD_LIST_ALL, 0, 16'd1, 16'd2, 0);
		send_word(CMD_LIST_ALL, 1, 16'hFFFF, 16'hFFFF, 0);
		send_word(CMD_LIST_ALL, 1, 16'd9, 16'd9, 0);
		send_word(CMD_FIND_FIRST, 0, 16'd0, 16'd2, 0);
		send_word(CMD_ADD_LINK, 0, 16'd5, 16'd0, 0);
		send_word(3'd6, 0, 16'd1, 16'd1, 1);
		send_word(3'd7, 1, 16'd1, 16'd1, 1);
		drain();

		write_reg(3'd0, 16'hFFFD);
		write_reg(3'd4, 16'hFFFE);
		send_word(CMD_FLUSH, 0, 0, 0, 0);
		send_word(CMD_ADD_NEURON, 0, 16'd1, 16'd1, 1);
		send_word(CMD_ADD_LINK, 0, 16'd1, 16'd1, 0);
		send_word(CMD_ADD_LINK, 0, 16'd1, 16'd1, 0);
		drain();
		write_reg(3'd0, 16'hFFFF);
		write_reg(3'd4, 16'd0);
		send_word(CMD_FLUSH, 0, 0, 0, 0);
		send_word(CMD_ADD_LINK, 0, 16'd1, 16'd1, 0);
		drain();
		write_reg(3'd0, 16'd0);
		write_reg(3'd4, 16'd100);
		send_word(CMD_FLUSH, 0, 0, 0, 0);
		for (int i = 0; i < 66; i++) send_word(CMD_ADD_LINK, 0, 16'd7, 16'd7, 0);
		send_word(CMD_ADD_NEURON, 0, 16'd7, 16'd7, 1);
		hold_off <= 400;
		for (int i = 0; i < 4; i++) send_word(CMD_LIST_ALL, 0, 16'd7, 16'd7, 0);
		drain();
		send_word(CMD_FLUSH, 0, 0, 0, 0);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 51 : 20) : 0;
			stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 51 : 20) : 0;
			for (int i = 0; i < 60; i++) random_word();
			drain();
			write_reg(3'd0, 16'($urandom_range(0, 40000)));
			write_reg(3'd4, 16'($urandom_range(0, 65535)));
			send_word(CMD_FLUSH, 0, 0, 0, 0);
		end
		drain();

		$display("Ran directed lookups, appends, exhaustion, full table and %0d result words",
			board.checked);
		$display("over four idle and stall mixes plus a long receiver hold-off.");
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
